FILE: rtl/bfbp_pkg.sv
// shared types, constants and codes of the best-fit buffer pool
package bfbp_pkg;

    // fixed field widths
    localparam int LEN_W         = 41;
    localparam int HANDLE_PORT_W = 16;
    localparam int EVICT_W       = 5;
    localparam int ACTION_W      = 2;

    // parameter defaults
    localparam int POOL_DEPTH_DEF  = 16;
    localparam int HANDLE_BITS_DEF = 16;

    // byte limit after reset: 2 GiB
    localparam logic [LEN_W-1:0] LIMIT_RESET = 41'd2147483648;

    // request action codes
    typedef logic [ACTION_W-1:0] t_action;
    localparam t_action ACT_TAKE  = 2'd0;
    localparam t_action ACT_PUT   = 2'd1;
    localparam t_action ACT_CLEAR = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic start;
        logic scan;
        logic shift_init;
        logic shift;
        logic take_commit;
        logic clear;
        logic ev_read;
        logic ev_commit;
        logic append;
        logic load_out;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        t_action action;
        logic    walk_done;
        logic    hit;
        logic    put_ok;
        logic    ev_need;
        logic    out_free;
    } t_status;

endpackage

FILE: rtl/bfbp_ctrl.sv
// controller state machine of the best-fit buffer pool
module bfbp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  bfbp_pkg::t_status i_status,
    output bfbp_pkg::t_cmd    o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_DISPATCH = 7'b0000010,
        S_SCAN     = 7'b0000100,
        S_SHIFT    = 7'b0001000,
        S_EV_CHECK = 7'b0010000,
        S_EV_SUB   = 7'b0100000,
        S_FINISH   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_cfg_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                // a pending limit write goes first, then a request
                o_cfg_ready = 1'b1;
                o_in_ready  = !i_cfg_valid;
                if (i_in_valid && !i_cfg_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_status.action)
                    bfbp_pkg::ACT_TAKE: begin
                        n_state = S_SCAN;
                    end
                    bfbp_pkg::ACT_PUT: begin
                        n_state = i_status.put_ok ? S_EV_CHECK : S_FINISH;
                    end
                    bfbp_pkg::ACT_CLEAR: begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_FINISH;
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.walk_done) begin
                    if (i_status.hit) begin
                        o_cmd.shift_init = 1'b1;
                        n_state          = S_SHIFT;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (i_status.walk_done) begin
                    o_cmd.take_commit = 1'b1;
                    n_state           = S_FINISH;
                end
            end
            S_EV_CHECK: begin
                if (i_status.ev_need) begin
                    o_cmd.ev_read = 1'b1;
                    n_state       = S_EV_SUB;
                end else begin
                    o_cmd.append = 1'b1;
                    n_state      = S_FINISH;
                end
            end
            S_EV_SUB: begin
                o_cmd.ev_commit = 1'b1;
                n_state         = S_EV_CHECK;
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/bfbp_dp.sv
// datapath of the best-fit buffer pool: entry memory, totals, scan and output register
module bfbp_dp #(
    parameter int POOL_DEPTH  = bfbp_pkg::POOL_DEPTH_DEF,
    parameter int HANDLE_BITS = bfbp_pkg::HANDLE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [bfbp_pkg::LEN_W-1:0]        i_cfg_limit,
    input  bfbp_pkg::t_action                 i_action,
    input  logic [bfbp_pkg::LEN_W-1:0]        i_size,
    input  logic [HANDLE_BITS-1:0]            i_handle,
    input  bfbp_pkg::t_cmd                    i_cmd,
    output bfbp_pkg::t_status                 o_status,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_found,
    output logic [HANDLE_BITS-1:0]            o_out_handle,
    output logic [bfbp_pkg::LEN_W-1:0]        o_out_length,
    output logic                              o_accepted,
    output logic [bfbp_pkg::EVICT_W-1:0]      o_evicted_count,
    output logic [bfbp_pkg::LEN_W-1:0]        o_cached_total
);

    localparam int AW = $clog2(POOL_DEPTH);
    localparam int CW = $clog2(POOL_DEPTH + 1);
    localparam int SW = AW + 1;
    localparam int LW = bfbp_pkg::LEN_W;
    localparam int EW = LW + HANDLE_BITS;

    // age-ordered ring of entries: length above handle
    logic [EW-1:0] r_mem [POOL_DEPTH];
    logic [EW-1:0] r_rd_data;

    logic [AW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic [LW-1:0] r_cached;
    logic [LW-1:0] r_limit;
    logic [LW-1:0] r_room;

    // captured request
    bfbp_pkg::t_action   r_action;
    logic [LW-1:0]       r_size;
    logic [HANDLE_BITS-1:0] r_handle;

    // walk over the ring and best-fit tracking
    logic [CW-1:0]       r_idx;
    logic [CW-1:0]       r_off_d;
    logic                r_vld;
    logic                r_hit;
    logic [CW-1:0]       r_best_off;
    logic [LW-1:0]       r_best_len;
    logic [HANDLE_BITS-1:0] r_best_handle;
    logic                r_acc;
    logic [bfbp_pkg::EVICT_W-1:0] r_evicted;

    // output register
    logic                r_out_valid;
    logic                r_found;
    logic [HANDLE_BITS-1:0] r_out_handle;
    logic [LW-1:0]       r_out_length;
    logic                r_accepted;
    logic [bfbp_pkg::EVICT_W-1:0] r_out_evicted;
    logic [LW-1:0]       r_out_cached;

    logic                rd_go;
    logic                mem_re;
    logic [AW-1:0]       rd_addr;
    logic                mem_we;
    logic [AW-1:0]       wr_addr;
    logic [EW-1:0]       wr_data;
    logic [LW-1:0]       rd_len;
    logic [HANDLE_BITS-1:0] rd_handle;
    logic [AW-1:0]       head_next;
    logic                better;

    // ring offset to memory address
    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] head,
                                             input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(head) + SW'(off);
        if (sum >= SW'(POOL_DEPTH)) begin
            sum = sum - SW'(POOL_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign rd_len    = r_rd_data[EW-1 -: LW];
    assign rd_handle = r_rd_data[HANDLE_BITS-1:0];
    assign head_next = (r_head == AW'(POOL_DEPTH - 1)) ? '0 : r_head + AW'(1);

    // one entry read per cycle while walking
    assign rd_go   = (i_cmd.scan || i_cmd.shift) && (r_idx < r_count);
    assign mem_re  = rd_go || i_cmd.ev_read;
    assign rd_addr = i_cmd.ev_read ? r_head : f_phys(r_head, r_idx);

    // candidate beats the best so far
    assign better = (rd_len >= r_size) && (!r_hit || (rd_len < r_best_len));

    // write port: shift down on take, append on put
    always_comb begin
        mem_we  = 1'b0;
        wr_addr = f_phys(r_head, r_count);
        wr_data = {r_size, r_handle};
        if (i_cmd.shift && r_vld) begin
            mem_we  = 1'b1;
            wr_addr = f_phys(r_head, r_off_d - CW'(1));
            wr_data = r_rd_data;
        end else if (i_cmd.append) begin
            mem_we = 1'b1;
        end
    end

    // memory write
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    // memory read, registered
    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // control state: limit, ring pointers, total, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= bfbp_pkg::LIMIT_RESET;
            r_head      <= '0;
            r_count     <= '0;
            r_cached    <= '0;
            r_vld       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_limit;
            end
            r_vld <= rd_go;
            if (i_cmd.take_commit) begin
                r_count  <= r_count - CW'(1);
                r_cached <= r_cached - r_best_len;
            end else if (i_cmd.ev_commit) begin
                r_count  <= r_count - CW'(1);
                r_cached <= r_cached - rd_len;
                r_head   <= head_next;
            end else if (i_cmd.append) begin
                r_count  <= r_count + CW'(1);
                r_cached <= r_cached + r_size;
            end else if (i_cmd.clear) begin
                r_count  <= '0;
                r_cached <= '0;
                r_head   <= '0;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request capture, walk, best fit and result payload
    always_ff @(posedge i_clk) begin
        r_off_d <= r_idx;
        r_room  <= r_limit - r_size;
        if (i_cmd.start) begin
            r_action  <= i_action;
            r_size    <= i_size;
            r_handle  <= i_handle;
            r_idx     <= '0;
            r_hit     <= 1'b0;
            r_acc     <= 1'b0;
            r_evicted <= '0;
        end else begin
            if (i_cmd.shift_init) begin
                r_idx <= r_best_off + CW'(1);
            end else if (rd_go) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.scan && r_vld && better) begin
                r_hit         <= 1'b1;
                r_best_off    <= r_off_d;
                r_best_len    <= rd_len;
                r_best_handle <= rd_handle;
            end
            if (i_cmd.ev_commit && (r_evicted != '1)) begin
                r_evicted <= r_evicted + bfbp_pkg::EVICT_W'(1);
            end
            if (i_cmd.append) begin
                r_acc <= 1'b1;
            end
        end
        if (i_cmd.load_out) begin
            r_found       <= (r_action == bfbp_pkg::ACT_TAKE) && r_hit;
            r_out_handle  <= ((r_action == bfbp_pkg::ACT_TAKE) && r_hit) ? r_best_handle : '0;
            r_out_length  <= ((r_action == bfbp_pkg::ACT_TAKE) && r_hit) ? r_best_len : '0;
            r_accepted    <= r_acc;
            r_out_evicted <= r_evicted;
            r_out_cached  <= r_cached;
        end
    end

    // status to the controller
    always_comb begin
        o_status.action    = r_action;
        o_status.walk_done = (r_idx == r_count) && !r_vld;
        o_status.hit       = r_hit;
        o_status.put_ok    = (r_handle != '0) && (r_size <= r_limit);
        o_status.ev_need   = ((r_count != '0) && (r_cached > r_room))
                             || (r_count == CW'(POOL_DEPTH));
        o_status.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid     = r_out_valid;
    assign o_found         = r_found;
    assign o_out_handle    = r_out_handle;
    assign o_out_length    = r_out_length;
    assign o_accepted      = r_accepted;
    assign o_evicted_count = r_out_evicted;
    assign o_cached_total  = r_out_cached;

endmodule

FILE: rtl/best_fit_buffer_pool.sv
// top level of the best-fit buffer pool with oldest-first eviction
// One request at a time. A take walks the cached entries through a memory with one
// read and one write port and registered read, one entry per cycle, then closes the
// gap by moving each younger entry down one slot per cycle; a miss skips the shift.
// A put passes an eviction check and a subtract state for each evicted entry, then
// appends; a dropped put, a clear or an unused action goes from dispatch to the
// result. The next request can be taken in the cycle after the result is loaded.
// The result sits in an output register, so the next request can be taken while it
// waits; a later result stalls until that register drains. byte_limit is written
// only while the pool is idle, ahead of any request offered in the same cycle, and
// is ready at once.
module best_fit_buffer_pool #(
    parameter int POOL_DEPTH  = bfbp_pkg::POOL_DEPTH_DEF,
    parameter int HANDLE_BITS = bfbp_pkg::HANDLE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [bfbp_pkg::LEN_W-1:0]           i_cfg_byte_limit,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [bfbp_pkg::ACTION_W-1:0]        i_action,
    input  logic [bfbp_pkg::LEN_W-1:0]           i_byte_size,
    input  logic [bfbp_pkg::HANDLE_PORT_W-1:0]   i_buffer_handle,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_found,
    output logic [bfbp_pkg::HANDLE_PORT_W-1:0]   o_out_handle,
    output logic [bfbp_pkg::LEN_W-1:0]           o_out_length,
    output logic                                 o_accepted,
    output logic [bfbp_pkg::EVICT_W-1:0]         o_evicted_count,
    output logic [bfbp_pkg::LEN_W-1:0]           o_cached_total
);

    bfbp_pkg::t_cmd    cmd;
    bfbp_pkg::t_status status;

    logic [HANDLE_BITS-1:0] in_handle;
    logic [HANDLE_BITS-1:0] dp_handle;
    logic                   cfg_we;

    // limit write strobe, only granted while idle
    assign cfg_we = i_cfg_valid && o_cfg_ready;

    // fit the handle port to the stored handle width
    for (genvar gi = 0; gi < HANDLE_BITS; gi++) begin : g_in_handle
        if (gi < bfbp_pkg::HANDLE_PORT_W) begin : g_bit
            assign in_handle[gi] = i_buffer_handle[gi];
        end else begin : g_zero
            assign in_handle[gi] = 1'b0;
        end
    end

    for (genvar go = 0; go < bfbp_pkg::HANDLE_PORT_W; go++) begin : g_out_handle
        if (go < HANDLE_BITS) begin : g_bit
            assign o_out_handle[go] = dp_handle[go];
        end else begin : g_zero
            assign o_out_handle[go] = 1'b0;
        end
    end

    // sequencing
    bfbp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // table, totals and result register
    bfbp_dp #(
        .POOL_DEPTH  (POOL_DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (cfg_we),
        .i_cfg_limit     (i_cfg_byte_limit),
        .i_action        (i_action),
        .i_size          (i_byte_size),
        .i_handle        (in_handle),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_found         (o_found),
        .o_out_handle    (dp_handle),
        .o_out_length    (o_out_length),
        .o_accepted      (o_accepted),
        .o_evicted_count (o_evicted_count),
        .o_cached_total  (o_cached_total)
    );

    // one request in flight: ready drops right after a request is taken
    a_one_in_flight : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second request taken while one is in flight");

    // a result is never both a take hit and a stored put
    a_found_xor_acc : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_found && o_accepted))
        else $error("result flags both a hit and a stored put");

    // a miss carries no handle and no length
    a_miss_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> ((o_out_handle == '0) && (o_out_length == '0)))
        else $error("miss result carries handle or length");

    // nothing is evicted unless the put was stored
    a_evict_put : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_evicted_count != '0)) |-> o_accepted)
        else $error("eviction reported without a stored put");

endmodule

FILE: sim/best_fit_buffer_pool_tb.sv
// testbench of the best-fit buffer pool: directed and random requests checked against a predictor
`timescale 1ns / 100ps

module best_fit_buffer_pool_tb;

    localparam int POOL_SLOTS = bfbp_pkg::POOL_DEPTH_DEF;
    localparam int LEN_BITS   = bfbp_pkg::LEN_W;
    localparam int HDL_BITS   = bfbp_pkg::HANDLE_PORT_W;
    localparam int EV_BITS    = bfbp_pkg::EVICT_W;
    localparam int ACT_BITS   = bfbp_pkg::ACTION_W;
    localparam int FIFO_SLOTS = 64;
    localparam int SETTLE     = 8;

    typedef logic [LEN_BITS-1:0] t_len;
    typedef logic [HDL_BITS-1:0] t_hdl;

    localparam bfbp_pkg::t_action ACT_UNUSED = 2'd3;
    localparam t_len              MAX_LEN    = 41'h100_0000_0000;

    typedef struct packed {
        logic               found;
        t_hdl               handle;
        t_len               length;
        logic               accepted;
        logic [EV_BITS-1:0] evicted;
        t_len               total;
    } t_pool_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    t_len                i_cfg_byte_limit;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [ACT_BITS-1:0] i_action;
    t_len                i_byte_size;
    t_hdl                i_buffer_handle;
    logic                o_out_valid;
    logic                i_out_ready;
    logic                o_found;
    t_hdl                o_out_handle;
    t_len                o_out_length;
    logic                o_accepted;
    logic [EV_BITS-1:0]  o_evicted_count;
    t_len                o_cached_total;

    // predicted pool contents, oldest first
    t_len pool_len [POOL_SLOTS];
    t_hdl pool_hdl [POOL_SLOTS];
    int   pool_count;
    t_len pool_bytes;
    t_len pool_limit;

    // expected results in request order
    t_pool_result exp_fifo [FIFO_SLOTS];
    int           exp_wr;
    int           exp_rd;
    int unsigned  fail_count;
    bit           idle_enable;
    int unsigned  sink_idle_left;
    int unsigned  hold_request;

    best_fit_buffer_pool dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_byte_limit (i_cfg_byte_limit),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_action         (i_action),
        .i_byte_size      (i_byte_size),
        .i_buffer_handle  (i_buffer_handle),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_found          (o_found),
        .o_out_handle     (o_out_handle),
        .o_out_length     (o_out_length),
        .o_accepted       (o_accepted),
        .o_evicted_count  (o_evicted_count),
        .o_cached_total   (o_cached_total)
    );

    always #1 i_clk = ~i_clk;

    // remove one entry, keeping the age order of the rest
    function automatic void drop_pool_entry(int idx);
        pool_bytes = pool_bytes - pool_len[idx];
        for (int i = idx; i + 1 < pool_count; i++) begin
            pool_len[i] = pool_len[i + 1];
            pool_hdl[i] = pool_hdl[i + 1];
        end
        pool_count--;
    endfunction

    // expected result of one request, updating the predicted pool
    function automatic t_pool_result predict_pool_step(bfbp_pkg::t_action act, t_len size,
                                                       t_hdl hdl);
        t_pool_result r;
        logic         hit;
        int           best;
        t_len         best_len;
        r        = '0;
        hit      = 1'b0;
        best     = 0;
        best_len = '0;
        case (act)
            bfbp_pkg::ACT_TAKE: begin
                // smallest fitting entry, oldest on a tie
                for (int i = 0; i < pool_count; i++) begin
                    if (pool_len[i] >= size && (!hit || pool_len[i] < best_len)) begin
                        hit      = 1'b1;
                        best     = i;
                        best_len = pool_len[i];
                    end
                end
                if (hit) begin
                    r.found  = 1'b1;
                    r.handle = pool_hdl[best];
                    r.length = best_len;
                    drop_pool_entry(best);
                end
            end
            bfbp_pkg::ACT_PUT: begin
                if (hdl != '0 && size <= pool_limit) begin
                    // evict oldest until the new buffer fits, then make room in a full table
                    while (pool_count > 0 && pool_bytes > pool_limit - size) begin
                        drop_pool_entry(0);
                        r.evicted = r.evicted + EV_BITS'(1);
                    end
                    if (pool_count >= POOL_SLOTS) begin
                        drop_pool_entry(0);
                        r.evicted = r.evicted + EV_BITS'(1);
                    end
                    pool_len[pool_count] = size;
                    pool_hdl[pool_count] = hdl;
                    pool_count++;
                    pool_bytes = pool_bytes + size;
                    r.accepted = 1'b1;
                end
            end
            bfbp_pkg::ACT_CLEAR: begin
                pool_count = 0;
                pool_bytes = '0;
            end
            default: ;
        endcase
        r.total = pool_bytes;
        return r;
    endfunction

    // uniform value in 0..top
    function automatic t_len rand_upto(t_len top);
        longint unsigned r;
        r = {$urandom, $urandom};
        return t_len'(r % (64'(top) + 64'd1));
    endfunction

    function automatic t_len pick_put_length(t_len lim);
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 60)
            return rand_upto(lim >> 3);
        else if (sel < 85)
            return rand_upto(lim);
        else if (sel < 95)
            return lim;
        else
            return rand_upto((lim < t_len'(16)) ? lim : t_len'(16));
    endfunction

    // take sizes aimed mostly at lengths now in the pool
    function automatic t_len pick_take_size(t_len lim);
        int unsigned sel;
        t_len        base;
        sel = $urandom_range(0, 99);
        if (pool_count > 0 && sel < 70) begin
            base = pool_len[$urandom_range(0, pool_count - 1)];
            if (sel < 30)
                return base;
            else if (sel < 55)
                return base - rand_upto(base >> 4);
            else
                return (base < MAX_LEN) ? base + t_len'(1) : base;
        end
        return rand_upto(lim);
    endfunction

    // offer one request and wait until it is taken; called and returns at a falling edge
    task automatic send_request(bfbp_pkg::t_action act, t_len size, t_hdl hdl);
        int unsigned gap;
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_action        <= act;
        i_byte_size     <= size;
        i_buffer_handle <= hdl;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // stop offering and wait until every result is back
    task automatic drain_pool_requests();
        i_in_valid <= 1'b0;
        while (exp_wr != exp_rd) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_byte_limit(t_len value);
        i_cfg_valid      <= 1'b1;
        i_cfg_byte_limit <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // one well-formed or noisy request against the current limit
    task automatic send_random_request(t_len lim);
        int unsigned kind;
        t_len        span;
        kind = $urandom_range(0, 99);
        if (kind < 48) begin
            send_request(bfbp_pkg::ACT_PUT, pick_put_length(lim),
                         t_hdl'($urandom_range(1, 65535)));
        end else if (kind < 86) begin
            send_request(bfbp_pkg::ACT_TAKE, pick_take_size(lim), t_hdl'($urandom));
        end else if (kind < 92) begin
            send_request(bfbp_pkg::ACT_PUT, rand_upto(lim), '0);
        end else if (kind < 98) begin
            // oversized put, or a null one where nothing can exceed the limit
            if (lim < MAX_LEN) begin
                span = MAX_LEN - lim - t_len'(1);
                send_request(bfbp_pkg::ACT_PUT,
                             lim + t_len'(1) + rand_upto((span < lim) ? span : lim),
                             t_hdl'($urandom_range(1, 65535)));
            end else begin
                send_request(bfbp_pkg::ACT_PUT, rand_upto(lim), '0);
            end
        end else begin
            send_request(bfbp_pkg::ACT_CLEAR, rand_upto(lim), t_hdl'($urandom));
        end
    endtask

    // take/put basics, ties, null and oversized puts, unused action, clear
    task automatic test_directed_requests();
        send_request(bfbp_pkg::ACT_TAKE, '0, '0);
        send_request(bfbp_pkg::ACT_PUT, 41'd100, 16'h0001);
        send_request(bfbp_pkg::ACT_PUT, 41'd50, 16'h0002);
        send_request(bfbp_pkg::ACT_PUT, 41'd100, 16'h0003);
        send_request(bfbp_pkg::ACT_TAKE, 41'd60, '0);
        send_request(bfbp_pkg::ACT_TAKE, '0, 16'hFFFF);
        send_request(bfbp_pkg::ACT_PUT, 41'd10, '0);
        send_request(bfbp_pkg::ACT_PUT, bfbp_pkg::LIMIT_RESET + t_len'(1), 16'hFFFF);
        send_request(bfbp_pkg::ACT_PUT, bfbp_pkg::LIMIT_RESET, 16'hFFFF);
        send_request(ACT_UNUSED, MAX_LEN, 16'h5A5A);
        send_request(bfbp_pkg::ACT_TAKE, MAX_LEN, '0);
        send_request(bfbp_pkg::ACT_CLEAR, '0, '0);
        drain_pool_requests();
    endtask

    // smallest and largest limits, and a limit lowered below the cached total
    task automatic test_limit_extremes();
        write_byte_limit(41'd1);
        send_request(bfbp_pkg::ACT_PUT, 41'd1, 16'h8000);
        send_request(bfbp_pkg::ACT_PUT, 41'd1, 16'h7FFF);
        send_request(bfbp_pkg::ACT_PUT, 41'd0, 16'h0005);
        send_request(bfbp_pkg::ACT_PUT, 41'd2, 16'h0006);
        drain_pool_requests();
        write_byte_limit(MAX_LEN);
        send_request(bfbp_pkg::ACT_PUT, MAX_LEN, 16'hAAAA);
        send_request(bfbp_pkg::ACT_TAKE, MAX_LEN, '0);
        send_request(bfbp_pkg::ACT_PUT, MAX_LEN - t_len'(1), 16'h5555);
        drain_pool_requests();
        write_byte_limit(41'd1);
        send_request(bfbp_pkg::ACT_TAKE, 41'd1, '0);
        send_request(bfbp_pkg::ACT_PUT, 41'd0, 16'h0009);
        drain_pool_requests();
    endtask

    // receiver holds off long enough for the pool to stall its input
    task automatic test_backpressure();
        write_byte_limit(41'd4096);
        hold_request = 400;
        repeat (40) send_random_request(pool_limit);
        drain_pool_requests();
    endtask

    // random traffic over several limits, no clear between them
    task automatic test_random_traffic();
        t_len limits [6];
        limits[0] = bfbp_pkg::LIMIT_RESET;
        limits[1] = MAX_LEN;
        limits[2] = 41'd4096;
        limits[3] = 41'd1;
        limits[4] = rand_upto(MAX_LEN - t_len'(1)) + t_len'(1);
        limits[5] = 41'd100000;
        for (int p = 0; p < 6; p++) begin
            write_byte_limit(limits[p]);
            // last stretch runs with no idling on either side
            idle_enable = (p != 5);
            repeat (180) send_random_request(limits[p]);
            drain_pool_requests();
        end
    endtask

    // receiver pacing: random stall bursts plus requested long hold-offs
    always @(negedge i_clk) begin : sink_pacing
        if (hold_request != 0) begin
            sink_idle_left = hold_request;
            hold_request   = 0;
        end
        if (sink_idle_left != 0) begin
            sink_idle_left = sink_idle_left - 1;
            i_out_ready <= 1'b0;
        end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            sink_idle_left = $urandom_range(1, 10) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // predict on each accepted request, then check each accepted result
    always @(posedge i_clk) begin : result_check
        t_pool_result want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                pool_limit = i_cfg_byte_limit;
            if (i_in_valid && o_in_ready) begin
                exp_fifo[exp_wr % FIFO_SLOTS] = predict_pool_step(i_action, i_byte_size,
                                                                  i_buffer_handle);
                exp_wr++;
            end
            if (o_out_valid && i_out_ready) begin
                if (exp_wr == exp_rd) begin
                    $error("result with no request waiting");
                    fail_count++;
                end else begin
                    want = exp_fifo[exp_rd % FIFO_SLOTS];
                    exp_rd++;
                    compare_field("found", 64'(want.found), 64'(o_found));
                    compare_field("out_handle", 64'(want.handle), 64'(o_out_handle));
                    compare_field("out_length", 64'(want.length), 64'(o_out_length));
                    compare_field("accepted", 64'(want.accepted), 64'(o_accepted));
                    compare_field("evicted_count", 64'(want.evicted), 64'(o_evicted_count));
                    compare_field("cached_total", 64'(want.total), 64'(o_cached_total));
                end
            end
        end
    end

    initial begin
        #1000000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_valid      = 1'b0;
        i_cfg_byte_limit = '0;
        i_in_valid       = 1'b0;
        i_action         = bfbp_pkg::ACT_TAKE;
        i_byte_size      = '0;
        i_buffer_handle  = '0;
        i_out_ready      = 1'b0;
        pool_count       = 0;
        pool_bytes       = '0;
        pool_limit       = bfbp_pkg::LIMIT_RESET;
        exp_wr           = 0;
        exp_rd           = 0;
        fail_count       = 0;
        idle_enable      = 1'b1;
        sink_idle_left   = 0;
        hold_request     = 0;
        for (int i = 0; i < POOL_SLOTS; i++) begin
            pool_len[i] = '0;
            pool_hdl[i] = '0;
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_requests();
        test_limit_extremes();
        test_backpressure();
        test_random_traffic();

        drain_pool_requests();
        repeat (40) @(posedge i_clk);
        if (exp_wr != exp_rd) begin
            $error("%0d results never arrived", exp_wr - exp_rd);
            fail_count++;
        end
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: best_fit_buffer_pool.f
rtl/bfbp_pkg.sv
rtl/bfbp_ctrl.sv
rtl/bfbp_dp.sv
rtl/best_fit_buffer_pool.sv
sim/best_fit_buffer_pool_tb.sv
